// ----- design/sorted_interval_table_editor_assert.svh -----
// Assertion helpers for the checker file.
`ifndef SORTED_INTERVAL_TABLE_EDITOR_ASSERT_SVH
`define SORTED_INTERVAL_TABLE_EDITOR_ASSERT_SVH

// Clocked on clk_i, off while rst_ni is low.
`define SITE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, also active during reset.
`define SITE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/site_pkg.sv -----
`timescale 1ns / 1ps
package site_pkg;

  localparam int unsigned SITE_MAX_ENTRIES   = 64;
  localparam int unsigned SITE_BUMP_TICKS    = 2205;
  localparam int unsigned SITE_MIN_LEN_TICKS = 1;

  localparam int unsigned TickW  = 40;
  localparam int unsigned IdW    = 32;
  localparam int unsigned AttrW  = 32;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CountW = 7;

  localparam logic [ReqW-1:0] REQ_INSERT  = 3'd0;
  localparam logic [ReqW-1:0] REQ_ERASE   = 3'd1;
  localparam logic [ReqW-1:0] REQ_MERGE   = 3'd2;
  localparam logic [ReqW-1:0] REQ_SPLIT   = 3'd3;
  localparam logic [ReqW-1:0] REQ_MOVE_L  = 3'd4;
  localparam logic [ReqW-1:0] REQ_MOVE_R  = 3'd5;
  localparam logic [ReqW-1:0] REQ_LOOKUP  = 3'd6;

  localparam logic [StatW-1:0] STAT_OK        = 3'd0;
  localparam logic [StatW-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [StatW-1:0] STAT_OVL_PREV  = 3'd2;
  localparam logic [StatW-1:0] STAT_OVL_NEXT  = 3'd3;
  localparam logic [StatW-1:0] STAT_TOO_SHORT = 3'd4;
  localparam logic [StatW-1:0] STAT_SPLIT_OUT = 3'd5;
  localparam logic [StatW-1:0] STAT_NO_ADJ    = 3'd6;
  localparam logic [StatW-1:0] STAT_FULL      = 3'd7;

  localparam logic CFG_CLIP   = 1'b0;
  localparam logic CFG_MINSEG = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TickW-1:0] s;
    logic [TickW-1:0] e;
    logic [AttrW-1:0] g;
    logic [AttrW-1:0] t;
    logic [AttrW-1:0] f;
  } rec_t;

endpackage

// ----- design/sorted_interval_table_editor.sv -----
`timescale 1ns / 1ps
// One request at a time. With n stored entries, lookup and split scan the entries in turn.
// Insert, merge and edge moves first sweep the table, then insertion-sort it through the
// memory's one read and one write port, then scan. A finished result sits in an output register,
// so the next request enters while it waits. Reset clears the entry count, state, clip and
// output valid and sets next id and minimum length to 1; the table memory is not reset.
module sorted_interval_table_editor
  import site_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES   = SITE_MAX_ENTRIES,
  parameter int unsigned BUMP_TICKS    = SITE_BUMP_TICKS,
  parameter int unsigned MIN_LEN_TICKS = SITE_MIN_LEN_TICKS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [TickW-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ReqW-1:0]   req_type_i,
  input  logic [IdW-1:0]    target_id_i,
  input  logic [TickW-1:0]  tick_a_i,
  input  logic [TickW-1:0]  tick_b_i,
  input  logic [AttrW-1:0]  gain_word_i,
  input  logic [AttrW-1:0]  tension_word_i,
  input  logic [AttrW-1:0]  flag_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [StatW-1:0]  status_o,
  output logic [IdW-1:0]    result_id_o,
  output logic [TickW-1:0]  start_out_o,
  output logic [TickW-1:0]  end_out_o,
  output logic [AttrW-1:0]  gain_out_o,
  output logic [AttrW-1:0]  tension_out_o,
  output logic [AttrW-1:0]  flags_out_o,
  output logic [CountW-1:0] entry_count_o
);

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_START   = 5'd1;
  localparam logic [4:0] S_INS     = 5'd2;
  localparam logic [4:0] S_NRM_RD  = 5'd3;
  localparam logic [4:0] S_NRM_WR  = 5'd4;
  localparam logic [4:0] S_SRT_I   = 5'd5;
  localparam logic [4:0] S_SRT_TMP = 5'd6;
  localparam logic [4:0] S_SRT_CMP = 5'd7;
  localparam logic [4:0] S_SRT_PUT = 5'd8;
  localparam logic [4:0] S_POST    = 5'd9;
  localparam logic [4:0] S_FND_RD  = 5'd10;
  localparam logic [4:0] S_FND_CHK = 5'd11;
  localparam logic [4:0] S_ISR_RD  = 5'd12;
  localparam logic [4:0] S_ISR_CHK = 5'd13;
  localparam logic [4:0] S_ERS_RD  = 5'd14;
  localparam logic [4:0] S_ERS_CHK = 5'd15;
  localparam logic [4:0] S_MRG_RD  = 5'd16;
  localparam logic [4:0] S_MRG_WR  = 5'd17;
  localparam logic [4:0] S_MSH_RD  = 5'd18;
  localparam logic [4:0] S_MSH_WR  = 5'd19;
  localparam logic [4:0] S_SPL_W0  = 5'd20;
  localparam logic [4:0] S_SPL_RD  = 5'd21;
  localparam logic [4:0] S_SPL_WR  = 5'd22;
  localparam logic [4:0] S_SPL_PUT = 5'd23;
  localparam logic [4:0] S_MV_RD   = 5'd24;
  localparam logic [4:0] S_MV_CHK  = 5'd25;
  localparam logic [4:0] S_DONE    = 5'd26;

  function automatic logic [TickW-1:0] sat_add(logic [TickW-1:0] a, logic [TickW-1:0] b);
    logic [TickW:0] v;
    v = {1'b0, a} + {1'b0, b};
    return v[TickW] ? '1 : v[TickW-1:0];
  endfunction

  function automatic logic [IdW-1:0] raise_id(logic [IdW-1:0] cur, logic [IdW-1:0] id);
    logic [IdW-1:0] want;
    want = (id == '1) ? id : id + IdW'(1);
    return (want > cur) ? want : cur;
  endfunction

  // Table memory, one read and one write port, read data registered.
  rec_t mem_q [MAX_ENTRIES];
  rec_t rdata_q;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [IdxW-1:0] raddr;
  rec_t            wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  logic [4:0]       state_q, state_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [IdW-1:0]   next_id_q, next_id_d;
  logic [TickW-1:0] clip_q, min_seg_q;
  logic [CntW-1:0]  k_q, k_d, i_q, i_d, j_q, j_d, w_q, w_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             hit_q, hit_d;
  rec_t             rec_q, rec_d, tmp_q, tmp_d;
  logic [StatW-1:0] stat_q, stat_d;
  logic [ReqW-1:0]  op_q, op_d;
  logic [IdW-1:0]   tid_q, tid_d;
  logic [TickW-1:0] ta_q, ta_d, tb_q, tb_d;
  logic [AttrW-1:0] g_q, g_d, t_q, t_d, f_q, f_d;

  logic             out_valid_q, out_valid_d;
  logic [StatW-1:0] out_stat_q, out_stat_d;
  rec_t             out_rec_q, out_rec_d;
  logic [CntW-1:0]  out_cnt_q, out_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q    <= '0;
      min_seg_q <= TickW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CLIP:   clip_q    <= cfg_data_i;
        CFG_MINSEG: min_seg_q <= cfg_data_i;
        default:    clip_q    <= clip_q;
      endcase
    end
  end

  // Per-entry normalize of the word just read.
  logic             clip_on;
  logic [TickW-1:0] n_s, n_e, room, bump;

  always_comb begin
    clip_on = ((op_q == REQ_MOVE_L) || (op_q == REQ_MOVE_R)) && (clip_q != '0);
    n_s = rdata_q.s;
    n_e = rdata_q.e;
    if (clip_on) begin
      if (n_s > clip_q) n_s = clip_q;
      if (n_e > clip_q) n_e = clip_q;
    end else if (n_e < sat_add(n_s, TickW'(MIN_LEN_TICKS))) begin
      n_e = sat_add(n_s, TickW'(MIN_LEN_TICKS));
    end
    room = clip_q - n_s;
    if (room == '0) room = TickW'(1);
    bump = TickW'(BUMP_TICKS);
    if (clip_on && (room < bump)) bump = room;
    if (n_e <= n_s) n_e = sat_add(n_s, bump);
  end

  logic             srt_gt;
  logic [TickW-1:0] ms;
  logic [TickW:0]   min_end;
  logic [TickW-1:0] prev_end, next_start;

  assign srt_gt = (rdata_q.s > tmp_q.s) || ((rdata_q.s == tmp_q.s) && (rdata_q.e > tmp_q.e));
  assign ms = (min_seg_q == '0) ? TickW'(1) : min_seg_q;
  assign min_end = {1'b0, rec_q.s} + {1'b0, ms};
  assign prev_end = (idx_q != '0) ? rdata_q.e : '0;
  assign next_start = ((CntW'(idx_q) + CntW'(1)) < used_q) ? rdata_q.s : clip_q;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;  used_d = used_q;  next_id_d = next_id_q;
    k_d = k_q;  i_d = i_q;  j_d = j_q;  w_d = w_q;  idx_d = idx_q;  hit_d = hit_q;
    rec_d = rec_q;  tmp_d = tmp_q;  stat_d = stat_q;
    op_d = op_q;  tid_d = tid_q;  ta_d = ta_q;  tb_d = tb_q;  g_d = g_q;  t_d = t_q;  f_d = f_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_stat_d = out_stat_q;  out_rec_d = out_rec_q;  out_cnt_d = out_cnt_q;
    we = 1'b0;  waddr = k_q[IdxW-1:0];  wdata = rdata_q;  raddr = k_q[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = req_type_i;  tid_d = target_id_i;  ta_d = tick_a_i;  tb_d = tick_b_i;
          g_d = gain_word_i;  t_d = tension_word_i;  f_d = flag_word_i;
          stat_d = STAT_OK;
          k_d = '0;
          state_d = S_START;
        end
      end
      S_START: begin
        unique case (op_q)
          REQ_INSERT: begin
            if (used_q == CntW'(MAX_ENTRIES)) begin
              stat_d = STAT_FULL;
              state_d = S_DONE;
            end else begin
              if (tid_q == '0) begin
                rec_d.id = next_id_q;
                if (next_id_q != '1) next_id_d = next_id_q + IdW'(1);
              end else begin
                rec_d.id = tid_q;
                next_id_d = raise_id(next_id_q, tid_q);
              end
              rec_d.s = ta_q;  rec_d.e = tb_q;  rec_d.g = g_q;  rec_d.t = t_q;  rec_d.f = f_q;
              state_d = S_INS;
            end
          end
          REQ_ERASE: begin
            w_d = '0;
            hit_d = 1'b0;
            state_d = S_ERS_RD;
          end
          REQ_MERGE, REQ_MOVE_L, REQ_MOVE_R: state_d = S_NRM_RD;
          REQ_SPLIT, REQ_LOOKUP:             state_d = S_FND_RD;
          default: begin
            stat_d = STAT_NOT_FOUND;
            state_d = S_DONE;
          end
        endcase
      end
      S_INS: begin
        we = 1'b1;
        waddr = used_q[IdxW-1:0];
        wdata = rec_q;
        used_d = used_q + CntW'(1);
        state_d = S_NRM_RD;
      end
      S_NRM_RD: begin
        if (k_q >= used_q) begin
          i_d = CntW'(1);
          state_d = S_SRT_I;
        end else begin
          state_d = S_NRM_WR;
        end
      end
      S_NRM_WR: begin
        we = 1'b1;
        wdata.s = n_s;
        wdata.e = n_e;
        next_id_d = raise_id(next_id_q, rdata_q.id);
        k_d = k_q + CntW'(1);
        state_d = S_NRM_RD;
      end
      S_SRT_I: begin
        raddr = i_q[IdxW-1:0];
        state_d = (i_q >= used_q) ? S_POST : S_SRT_TMP;
      end
      S_SRT_TMP: begin
        tmp_d = rdata_q;
        j_d = i_q;
        raddr = IdxW'(i_q - CntW'(1));
        state_d = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        we = 1'b1;
        waddr = j_q[IdxW-1:0];
        if (srt_gt) begin
          // Shift the larger entry up and keep walking down.
          wdata = rdata_q;
          j_d = j_q - CntW'(1);
          raddr = IdxW'(j_q - CntW'(2));
          if (j_q == CntW'(1)) state_d = S_SRT_PUT;
        end else begin
          wdata = tmp_q;
          i_d = i_q + CntW'(1);
          state_d = S_SRT_I;
        end
      end
      S_SRT_PUT: begin
        we = 1'b1;
        waddr = j_q[IdxW-1:0];
        wdata = tmp_q;
        i_d = i_q + CntW'(1);
        state_d = S_SRT_I;
      end
      S_POST: begin
        if (op_q == REQ_INSERT) begin
          k_d = used_q;
          state_d = S_ISR_RD;
        end else begin
          k_d = '0;
          state_d = S_FND_RD;
        end
      end
      S_FND_RD: begin
        if ((op_q == REQ_MERGE) ? ((k_q + CntW'(1)) >= used_q) : (k_q >= used_q)) begin
          stat_d = (op_q == REQ_MERGE) ? STAT_NO_ADJ : STAT_NOT_FOUND;
          state_d = S_DONE;
        end else begin
          state_d = S_FND_CHK;
        end
      end
      S_FND_CHK: begin
        if (rdata_q.id == tid_q) begin
          idx_d = k_q[IdxW-1:0];
          rec_d = rdata_q;
          unique case (op_q)
            REQ_SPLIT: begin
              if ((ta_q <= rdata_q.s) || (ta_q >= rdata_q.e)) begin
                stat_d = STAT_SPLIT_OUT;
                state_d = S_DONE;
              end else if (used_q == CntW'(MAX_ENTRIES)) begin
                stat_d = STAT_FULL;
                state_d = S_DONE;
              end else begin
                state_d = S_SPL_W0;
              end
            end
            REQ_MERGE:             state_d = S_MRG_RD;
            REQ_MOVE_L, REQ_MOVE_R: state_d = S_MV_RD;
            default:               state_d = S_DONE;
          endcase
        end else begin
          k_d = k_q + CntW'(1);
          state_d = S_FND_RD;
        end
      end
      S_ISR_RD: begin
        raddr = IdxW'(k_q - CntW'(1));
        if (k_q == '0) begin
          rec_d = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_ISR_CHK;
        end
      end
      S_ISR_CHK: begin
        if ((rdata_q.id == rec_q.id) && (rdata_q.g == rec_q.g) && (rdata_q.t == rec_q.t) &&
            (rdata_q.f == rec_q.f) && (rdata_q.s == ta_q)) begin
          rec_d = rdata_q;
          state_d = S_DONE;
        end else begin
          k_d = k_q - CntW'(1);
          state_d = S_ISR_RD;
        end
      end
      S_ERS_RD: begin
        if (k_q >= used_q) begin
          used_d = w_q;
          stat_d = hit_q ? STAT_OK : STAT_NOT_FOUND;
          state_d = S_DONE;
        end else begin
          state_d = S_ERS_CHK;
        end
      end
      S_ERS_CHK: begin
        if (rdata_q.id == tid_q) begin
          if (!hit_q) begin
            rec_d = rdata_q;
            hit_d = 1'b1;
          end
        end else begin
          we = 1'b1;
          waddr = w_q[IdxW-1:0];
          w_d = w_q + CntW'(1);
        end
        k_d = k_q + CntW'(1);
        state_d = S_ERS_RD;
      end
      S_MRG_RD: begin
        raddr = idx_q + IdxW'(1);
        state_d = S_MRG_WR;
      end
      S_MRG_WR: begin
        rec_d.e = rdata_q.e;
        we = 1'b1;
        waddr = idx_q;
        wdata = rec_q;
        wdata.e = rdata_q.e;
        k_d = CntW'(idx_q) + CntW'(1);
        state_d = S_MSH_RD;
      end
      S_MSH_RD: begin
        raddr = IdxW'(k_q + CntW'(1));
        if ((k_q + CntW'(1)) < used_q) begin
          state_d = S_MSH_WR;
        end else begin
          used_d = used_q - CntW'(1);
          state_d = S_DONE;
        end
      end
      S_MSH_WR: begin
        we = 1'b1;
        k_d = k_q + CntW'(1);
        state_d = S_MSH_RD;
      end
      S_SPL_W0: begin
        we = 1'b1;
        waddr = idx_q;
        wdata = rec_q;
        wdata.e = ta_q;
        rec_d.id = next_id_q;
        rec_d.s = ta_q;
        if (next_id_q != '1) next_id_d = next_id_q + IdW'(1);
        k_d = used_q;
        state_d = S_SPL_RD;
      end
      S_SPL_RD: begin
        raddr = IdxW'(k_q - CntW'(1));
        state_d = (k_q > (CntW'(idx_q) + CntW'(1))) ? S_SPL_WR : S_SPL_PUT;
      end
      S_SPL_WR: begin
        we = 1'b1;
        k_d = k_q - CntW'(1);
        state_d = S_SPL_RD;
      end
      S_SPL_PUT: begin
        we = 1'b1;
        waddr = idx_q + IdxW'(1);
        wdata = rec_q;
        used_d = used_q + CntW'(1);
        state_d = S_DONE;
      end
      S_MV_RD: begin
        raddr = (op_q == REQ_MOVE_L) ? (idx_q - IdxW'(1)) : (idx_q + IdxW'(1));
        state_d = S_MV_CHK;
      end
      S_MV_CHK: begin
        waddr = idx_q;
        state_d = S_DONE;
        if (op_q == REQ_MOVE_L) begin
          if (ta_q <= prev_end) begin
            stat_d = STAT_OVL_PREV;
          end else if ((rec_q.e < ms) || (ta_q > (rec_q.e - ms))) begin
            stat_d = STAT_TOO_SHORT;
          end else begin
            rec_d.s = ta_q;
            we = 1'b1;
            wdata = rec_q;
            wdata.s = ta_q;
          end
        end else begin
          if (ta_q >= next_start) begin
            stat_d = STAT_OVL_NEXT;
          end else if ({1'b0, ta_q} < min_end) begin
            stat_d = STAT_TOO_SHORT;
          end else begin
            rec_d.e = ta_q;
            we = 1'b1;
            wdata = rec_q;
            wdata.e = ta_q;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_stat_d = stat_q;
          out_rec_d = (stat_q == STAT_OK) ? rec_q : '0;
          out_cnt_d = used_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      next_id_q   <= IdW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      next_id_q   <= next_id_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;  i_q <= i_d;  j_q <= j_d;  w_q <= w_d;  idx_q <= idx_d;  hit_q <= hit_d;
    rec_q <= rec_d;  tmp_q <= tmp_d;  stat_q <= stat_d;
    op_q <= op_d;  tid_q <= tid_d;  ta_q <= ta_d;  tb_q <= tb_d;
    g_q <= g_d;  t_q <= t_d;  f_q <= f_d;
    out_stat_q <= out_stat_d;  out_rec_q <= out_rec_d;  out_cnt_q <= out_cnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_stat_q;
  assign result_id_o   = out_rec_q.id;
  assign start_out_o   = out_rec_q.s;
  assign end_out_o     = out_rec_q.e;
  assign gain_out_o    = out_rec_q.g;
  assign tension_out_o = out_rec_q.t;
  assign flags_out_o   = out_rec_q.f;
  assign entry_count_o = CountW'(out_cnt_q);

endmodule

// ----- design/site_checker.sv -----
`timescale 1ns / 1ps
`include "sorted_interval_table_editor_assert.svh"
module site_checker
  import site_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = SITE_MAX_ENTRIES
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [StatW-1:0]  status_o,
  input logic [IdW-1:0]    result_id_o,
  input logic [TickW-1:0]  start_out_o,
  input logic [TickW-1:0]  end_out_o,
  input logic [AttrW-1:0]  gain_out_o,
  input logic [AttrW-1:0]  tension_out_o,
  input logic [AttrW-1:0]  flags_out_o,
  input logic [CountW-1:0] entry_count_o
);

  logic [StatW+IdW+2*TickW+3*AttrW+CountW-1:0] out_word;
  logic out_waiting;
  logic out_failed;
  logic out_fields_zero;
  logic in_taken;

  assign out_word = {status_o, result_id_o, start_out_o, end_out_o, gain_out_o,
                     tension_out_o, flags_out_o, entry_count_o};
  assign out_waiting = out_valid_o && out_stall_i;
  assign out_failed = out_valid_o && (status_o != STAT_OK);
  assign out_fields_zero = (result_id_o == '0) && (start_out_o == '0) && (end_out_o == '0) &&
                           (gain_out_o == '0) && (tension_out_o == '0) && (flags_out_o == '0);
  assign in_taken = in_valid_i && !in_stall_o;

  // A waiting result holds until it is taken.
  `SITE_ASSERT(a_out_hold, out_waiting |=> out_valid_o && $stable(out_word), "stalled result changed")

  // A failed request shows nothing but its status and the count.
  `SITE_ASSERT(a_fail_zero, out_failed |-> out_fields_zero, "failed request carries data")

  // The table never reports more entries than it can hold.
  `SITE_ASSERT(a_count_max, out_valid_o |-> (32'(entry_count_o) <= MAX_ENTRIES), "count too big")

  // After a request is taken the block is busy on the next cycle.
  `SITE_ASSERT(a_busy_after_req, in_taken |=> in_stall_o, "request not held off while working")

endmodule

bind sorted_interval_table_editor site_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_site_checker (.*);

// ----- verif/tb_sorted_interval_table_editor.sv -----
`timescale 1ns / 1ps
module tb_sorted_interval_table_editor;
  import site_pkg::*;

  localparam logic [TickW-1:0] TICK_TOP = {TickW{1'b1}};
  localparam logic [IdW-1:0]   ID_TOP   = {IdW{1'b1}};
  localparam int unsigned      N_ENT    = SITE_MAX_ENTRIES;
  localparam logic [ReqW-1:0]  REQ_UNKNOWN = 3'd7;

  typedef struct {
    logic [ReqW-1:0]  kind;
    logic [IdW-1:0]   tid;
    logic [TickW-1:0] ta;
    logic [TickW-1:0] tb;
    logic [AttrW-1:0] g;
    logic [AttrW-1:0] t;
    logic [AttrW-1:0] f;
  } request_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [IdW-1:0]    id;
    logic [TickW-1:0]  s;
    logic [TickW-1:0]  e;
    logic [AttrW-1:0]  g;
    logic [AttrW-1:0]  t;
    logic [AttrW-1:0]  f;
    logic [CountW-1:0] cnt;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [TickW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ReqW-1:0] req_type_i = '0;
  logic [IdW-1:0] target_id_i = '0;
  logic [TickW-1:0] tick_a_i = '0;
  logic [TickW-1:0] tick_b_i = '0;
  logic [AttrW-1:0] gain_word_i = '0;
  logic [AttrW-1:0] tension_word_i = '0;
  logic [AttrW-1:0] flag_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [StatW-1:0] status_o;
  logic [IdW-1:0] result_id_o;
  logic [TickW-1:0] start_out_o;
  logic [TickW-1:0] end_out_o;
  logic [AttrW-1:0] gain_out_o;
  logic [AttrW-1:0] tension_out_o;
  logic [AttrW-1:0] flags_out_o;
  logic [CountW-1:0] entry_count_o;

  sorted_interval_table_editor u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the interval table and its registers.
  rec_t             tbl [N_ENT+1];
  int unsigned      used;
  logic [IdW-1:0]   next_free_id;
  logic [TickW-1:0] clip_ticks;
  logic [TickW-1:0] min_seg;

  outcome_t pending_results[$];
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned status_hits[8];
  bit idle_off;
  bit out_stall_off;

  function automatic logic [TickW-1:0] tick_sat_add(logic [TickW-1:0] a, logic [TickW-1:0] b);
    logic [TickW:0] v;
    v = {1'b0, a} + {1'b0, b};
    return v[TickW] ? TICK_TOP : v[TickW-1:0];
  endfunction

  function automatic logic [IdW-1:0] take_fresh_id();
    logic [IdW-1:0] v;
    v = next_free_id;
    if (next_free_id != ID_TOP) next_free_id++;
    return v;
  endfunction

  function automatic void bump_next_id(logic [IdW-1:0] id);
    logic [IdW-1:0] want;
    want = (id == ID_TOP) ? ID_TOP : id + IdW'(1);
    if (want > next_free_id) next_free_id = want;
  endfunction

  function automatic void sort_intervals();
    rec_t tmp;
    int j;
    for (int i = 1; i < used; i++) begin
      tmp = tbl[i];
      j = i;
      while (j > 0 && (tbl[j-1].s > tmp.s || (tbl[j-1].s == tmp.s && tbl[j-1].e > tmp.e))) begin
        tbl[j] = tbl[j-1];
        j--;
      end
      tbl[j] = tmp;
    end
  endfunction

  function automatic void tidy_intervals(logic [TickW-1:0] clip);
    logic [TickW-1:0] s, e, bump, room;
    for (int i = 0; i < used; i++) begin
      s = tbl[i].s;
      e = tbl[i].e;
      if (clip != '0) begin
        if (s > clip) s = clip;
        if (e > clip) e = clip;
      end else if (e < tick_sat_add(s, TickW'(SITE_MIN_LEN_TICKS))) begin
        e = tick_sat_add(s, TickW'(SITE_MIN_LEN_TICKS));
      end
      if (e <= s) begin
        bump = TickW'(SITE_BUMP_TICKS);
        if (clip != '0) begin
          room = clip - s;
          if (room == '0) room = TickW'(1);
          if (room < bump) bump = room;
        end
        e = tick_sat_add(s, bump);
      end
      tbl[i].s = s;
      tbl[i].e = e;
    end
    sort_intervals();
    for (int i = 0; i < used; i++) bump_next_id(tbl[i].id);
  endfunction

  function automatic int find_first(logic [IdW-1:0] id);
    for (int i = 0; i < used; i++) if (tbl[i].id == id) return i;
    return -1;
  endfunction

  function automatic void show_entry(ref outcome_t o, input int i);
    o.id = tbl[i].id;
    o.s  = tbl[i].s;
    o.e  = tbl[i].e;
    o.g  = tbl[i].g;
    o.t  = tbl[i].t;
    o.f  = tbl[i].f;
  endfunction

  function automatic outcome_t apply_request(request_t rq);
    outcome_t o;
    rec_t r;
    int idx, w;
    bit hit;
    logic [TickW-1:0] ms, lim, nxt;
    logic [TickW:0] min_end;
    logic [StatW-1:0] st;
    o = '{default: '0};
    o.status = STAT_OK;
    case (rq.kind)
      REQ_INSERT: begin
        if (used >= N_ENT) begin
          o.status = STAT_FULL;
        end else begin
          if (rq.tid == '0) r.id = take_fresh_id();
          else begin
            r.id = rq.tid;
            bump_next_id(rq.tid);
          end
          r.s = rq.ta; r.e = rq.tb; r.g = rq.g; r.t = rq.t; r.f = rq.f;
          tbl[used] = r;
          used++;
          tidy_intervals('0);
          for (int k = int'(used) - 1; k >= 0; k--)
            if (tbl[k].id == r.id && tbl[k].g == r.g && tbl[k].t == r.t &&
                tbl[k].f == r.f && tbl[k].s == rq.ta) begin
              show_entry(o, k);
              break;
            end
        end
      end
      REQ_ERASE: begin
        w = 0;
        hit = 0;
        for (int k = 0; k < used; k++) begin
          if (tbl[k].id == rq.tid) begin
            if (!hit) show_entry(o, k);
            hit = 1;
          end else begin
            tbl[w] = tbl[k];
            w++;
          end
        end
        used = w;
        if (!hit) o.status = STAT_NOT_FOUND;
      end
      REQ_MERGE: begin
        tidy_intervals('0);
        idx = -1;
        for (int k = 0; k + 1 < used; k++)
          if (tbl[k].id == rq.tid) begin
            idx = k;
            break;
          end
        if (idx < 0) o.status = STAT_NO_ADJ;
        else begin
          tbl[idx].e = tbl[idx+1].e;
          for (int k = idx + 1; k + 1 < used; k++) tbl[k] = tbl[k+1];
          used--;
          show_entry(o, idx);
        end
      end
      REQ_SPLIT: begin
        idx = find_first(rq.tid);
        if (idx < 0) o.status = STAT_NOT_FOUND;
        else if (rq.ta <= tbl[idx].s || rq.ta >= tbl[idx].e) o.status = STAT_SPLIT_OUT;
        else if (used >= N_ENT) o.status = STAT_FULL;
        else begin
          r = tbl[idx];
          r.id = take_fresh_id();
          r.s = rq.ta;
          tbl[idx].e = rq.ta;
          for (int k = used; k > idx + 1; k--) tbl[k] = tbl[k-1];
          tbl[idx+1] = r;
          used++;
          show_entry(o, idx + 1);
        end
      end
      REQ_MOVE_L, REQ_MOVE_R: begin
        ms = (min_seg == '0) ? TickW'(1) : min_seg;
        tidy_intervals(clip_ticks);
        idx = find_first(rq.tid);
        if (idx < 0) o.status = STAT_NOT_FOUND;
        else if (rq.kind == REQ_MOVE_L) begin
          lim = (idx > 0) ? tbl[idx-1].e : '0;
          if (rq.ta <= lim) o.status = STAT_OVL_PREV;
          else if (tbl[idx].e < ms || rq.ta > tbl[idx].e - ms) o.status = STAT_TOO_SHORT;
          else begin
            tbl[idx].s = rq.ta;
            show_entry(o, idx);
          end
        end else begin
          nxt = (idx + 1 < used) ? tbl[idx+1].s : clip_ticks;
          // The minimum end may run past the tick range.
          min_end = {1'b0, tbl[idx].s} + {1'b0, ms};
          if (rq.ta >= nxt) o.status = STAT_OVL_NEXT;
          else if ({1'b0, rq.ta} < min_end) o.status = STAT_TOO_SHORT;
          else begin
            tbl[idx].e = rq.ta;
            show_entry(o, idx);
          end
        end
      end
      REQ_LOOKUP: begin
        idx = find_first(rq.tid);
        if (idx < 0) o.status = STAT_NOT_FOUND;
        else show_entry(o, idx);
      end
      default: o.status = STAT_NOT_FOUND;
    endcase
    if (o.status != STAT_OK) begin
      st = o.status;
      o = '{default: '0};
      o.status = st;
    end
    o.cnt = CountW'(used);
    return o;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (idle_off) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  task automatic send_request(request_t rq);
    bit stalled;
    outcome_t o;
    logic [StatW-1:0] st;
    req_type_i     <= rq.kind;
    target_id_i    <= rq.tid;
    tick_a_i       <= rq.ta;
    tick_b_i       <= rq.tb;
    gain_word_i    <= rq.g;
    tension_word_i <= rq.t;
    flag_word_i    <= rq.f;
    in_valid_i     <= 1'b1;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    o = apply_request(rq);
    // Failed requests report only status and count.
    if (o.status != STAT_OK) begin
      st = o.status;
      o = '{default: '0};
      o.status = st;
      o.cnt = CountW'(used);
    end
    pending_results = {pending_results, o};
    status_hits[o.status]++;
    requests_sent++;
    begin
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_all_results();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    wait (pending_results.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [TickW-1:0] val);
    wait_all_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CLIP) clip_ticks = val;
    else min_seg = val;
    @(posedge clk_i);
  endtask

  function automatic request_t make_req(logic [ReqW-1:0] kind, logic [IdW-1:0] tid,
                                        logic [TickW-1:0] ta, logic [TickW-1:0] tb);
    request_t rq;
    rq.kind = kind; rq.tid = tid; rq.ta = ta; rq.tb = tb;
    rq.g = $urandom; rq.t = $urandom; rq.f = $urandom;
    return rq;
  endfunction

  function automatic logic [TickW-1:0] rand_tick();
    int unsigned p;
    p = $urandom_range(0, 19);
    if (p == 0) return TickW'({$urandom, $urandom});
    if (p == 1) return TICK_TOP - TickW'($urandom_range(0, 5000));
    return TickW'($urandom_range(0, 200000));
  endfunction

  function automatic logic [TickW-1:0] near_tick(logic [TickW-1:0] base);
    logic [TickW-1:0] d;
    d = TickW'($urandom_range(0, 3000));
    case ($urandom_range(0, 3))
      0: return tick_sat_add(base, d);
      1: return (base > d) ? base - d : '0;
      2: return base;
      default: return rand_tick();
    endcase
  endfunction

  function automatic request_t random_req();
    request_t rq;
    int unsigned p;
    int x;
    logic [TickW-1:0] span;
    rq = make_req(REQ_LOOKUP, '0, rand_tick(), rand_tick());
    x = (used > 0) ? int'($urandom_range(0, used - 1)) : -1;
    if (x >= 0 && $urandom_range(0, 9) < 8) rq.tid = tbl[x].id;
    else rq.tid = ($urandom_range(0, 9) < 5) ? IdW'($urandom_range(0, 300)) : IdW'($urandom);
    p = $urandom_range(0, 99);
    if (used < 6 && p < 60) p = 0;
    if (p < 25) begin
      rq.kind = REQ_INSERT;
      rq.tid = ($urandom_range(0, 9) < 8) ? '0 : IdW'($urandom_range(1, 400));
      rq.ta = rand_tick();
      case ($urandom_range(0, 5))
        0: rq.tb = rand_tick();
        1: rq.tb = (rq.ta > TickW'(10)) ? rq.ta - TickW'($urandom_range(0, 10)) : '0;
        default: rq.tb = tick_sat_add(rq.ta, TickW'($urandom_range(0, 5000)));
      endcase
    end else if (p < 33) rq.kind = REQ_ERASE;
    else if (p < 41) rq.kind = REQ_MERGE;
    else if (p < 53) begin
      rq.kind = REQ_SPLIT;
      if (x >= 0 && $urandom_range(0, 3) != 0 && tbl[x].e > tbl[x].s + TickW'(1)) begin
        span = tbl[x].e - tbl[x].s - TickW'(1);
        rq.ta = tbl[x].s + TickW'(1) + TickW'({$urandom, $urandom} % 64'(span));
      end else if (x >= 0) rq.ta = near_tick(tbl[x].s);
    end else if (p < 67) begin
      rq.kind = REQ_MOVE_L;
      if (x >= 0) rq.ta = near_tick(tbl[x].s);
    end else if (p < 81) begin
      rq.kind = REQ_MOVE_R;
      if (x >= 0) rq.ta = near_tick(tbl[x].e);
    end else if (p < 97) rq.kind = REQ_LOOKUP;
    else rq.kind = REQ_UNKNOWN;
    return rq;
  endfunction

  // Result side: stall is changed at the rising edge and sampled at the falling edge.
  initial begin
    outcome_t exp_o, got;
    bit take;
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      take = out_valid_o && !out_stall_i;
      got.status = status_o;     got.id = result_id_o;
      got.s = start_out_o;       got.e = end_out_o;
      got.g = gain_out_o;        got.t = tension_out_o;
      got.f = flags_out_o;       got.cnt = entry_count_o;
      @(posedge clk_i);
      if (take) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result, status %0d", got.status);
        end else begin
          exp_o = pending_results.pop_front();
          if (got !== exp_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d id=%h s=%h e=%h g=%h t=%h f=%h n=%0d\n",
                       exp_o.status, exp_o.id, exp_o.s, exp_o.e, exp_o.g, exp_o.t,
                       exp_o.f, exp_o.cnt,
                       "          got st=%0d id=%h s=%h e=%h g=%h t=%h f=%h n=%0d",
                       got.status, got.id, got.s, got.e, got.g, got.t, got.f, got.cnt);
          end
        end
      end
      if (hold != 0) hold--;
      else if (out_stall_off) out_stall_i <= 1'b0;
      else begin
        case ($urandom_range(0, 99)) inside
          [0:64]:  out_stall_i <= 1'b0;
          [65:96]: begin out_stall_i <= 1'b1; hold = $urandom_range(0, 3); end
          default: begin out_stall_i <= 1'b1; hold = $urandom_range(20, 150); end
        endcase
      end
    end
  end

  task automatic test_directed();
    request_t rq;
    send_request(make_req(REQ_LOOKUP, 32'd1, '0, '0));
    send_request(make_req(REQ_INSERT, '0, 40'd100, 40'd50));
    send_request(make_req(REQ_INSERT, '0, 40'd200, 40'd400));
    rq = make_req(REQ_INSERT, 32'd7, 40'd300, 40'd500);
    rq.g = '1; rq.t = '1; rq.f = '1;
    send_request(rq);
    rq = make_req(REQ_INSERT, '0, 40'd0, 40'd0);
    rq.g = '0; rq.t = '0; rq.f = '0;
    send_request(rq);
    send_request(make_req(REQ_INSERT, '0, TICK_TOP, '0));
    send_request(make_req(REQ_LOOKUP, 32'd2, '0, '0));
    send_request(make_req(REQ_LOOKUP, 32'd999, '0, '0));
    send_request(make_req(REQ_SPLIT, 32'd2, 40'd300, '0));
    send_request(make_req(REQ_SPLIT, 32'd2, 40'd200, '0));
    send_request(make_req(REQ_SPLIT, 32'd999, 40'd250, '0));
    send_request(make_req(REQ_MERGE, 32'd1, '0, '0));
    send_request(make_req(REQ_MERGE, 32'd4, '0, '0));
    send_request(make_req(REQ_MOVE_L, 32'd7, 40'd0, '0));
    send_request(make_req(REQ_MOVE_L, 32'd7, 40'd499, '0));
    send_request(make_req(REQ_MOVE_R, 32'd4, TICK_TOP, '0));
    send_request(make_req(REQ_MOVE_R, 32'd5, 40'd0, '0));
    send_request(make_req(REQ_ERASE, 32'd7, '0, '0));
    send_request(make_req(REQ_ERASE, 32'd999, '0, '0));
    send_request(make_req(REQ_UNKNOWN, 32'd1, TICK_TOP, TICK_TOP));
    // Edge moves with clamping active.
    write_register(CFG_CLIP, 40'd350);
    send_request(make_req(REQ_MOVE_R, 32'd2, 40'd340, '0));
    send_request(make_req(REQ_MOVE_L, 32'd2, 40'd250, '0));
    wait_all_results();
  endtask

  task automatic test_table_full();
    write_register(CFG_CLIP, '0);
    while (used < N_ENT) send_request(make_req(REQ_INSERT, '0, rand_tick(), rand_tick()));
    send_request(make_req(REQ_INSERT, '0, 40'd5, 40'd10));
    for (int k = 0; k < 3; k++) begin
      send_request(make_req(REQ_SPLIT, tbl[k].id, tbl[k].s + TickW'(1), '0));
    end
    while (used > 4) send_request(make_req(REQ_ERASE, tbl[$urandom_range(0, used-1)].id, '0, '0));
  endtask

  task automatic test_random_phase(logic [TickW-1:0] clip, logic [TickW-1:0] mseg,
                                   int unsigned count);
    write_register(CFG_CLIP, clip);
    write_register(CFG_MINSEG, mseg);
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 100 == 50) idle_off = ~idle_off;
      if (k % 150 == 75) out_stall_off = ~out_stall_off;
      if (k == count / 2) wait_all_results();
      send_request(random_req());
    end
    idle_off = 0;
    out_stall_off = 0;
  endtask

  task automatic test_id_saturation();
    send_request(make_req(REQ_INSERT, ID_TOP, 40'd1000, 40'd2000));
    send_request(make_req(REQ_INSERT, '0, 40'd3000, 40'd4000));
    send_request(make_req(REQ_SPLIT, ID_TOP, 40'd1500, '0));
    send_request(make_req(REQ_LOOKUP, ID_TOP, '0, '0));
  endtask

  initial begin
    used = 0;
    next_free_id = IdW'(1);
    clip_ticks = '0;
    min_seg = TickW'(1);
    mismatches = 0;
    idle_off = 0;
    out_stall_off = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random_phase('0, 40'd1, 300);
    test_random_phase(40'd150000, 40'd1, 300);
    test_random_phase(TICK_TOP, TICK_TOP, 250);
    test_random_phase(40'd3000, 40'd500, 250);
    test_random_phase(40'd1, 40'd1, 150);
    test_random_phase(40'd100000, 40'd20, 300);
    test_random_phase('0, 40'd2000, 250);
    test_id_saturation();
    wait_all_results();
    repeat (200) @(posedge clk_i);
    if (pending_results.size() != 0) mismatches++;
    $display("Covered %0d requests over several clip and minimum-length settings;",
             requests_sent);
    $display("status counts ok..full: %0d %0d %0d %0d %0d %0d %0d %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5], status_hits[6], status_hits[7]);
    if (mismatches == 0) begin
      $display("sorted_interval_table_editor test passed");
    end else begin
      $display("sorted_interval_table_editor test failed");
    end
    $finish;
  end

  initial begin
    #300ms;
    $display("sorted_interval_table_editor test failed");
    $finish;
  end

endmodule
